/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker file vra_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/vra_pkg.sv */
package vra_pkg;

  localparam int CPU_W   = 12;
  localparam int MEM_W   = 20;
  localparam int INDEX_W = 8;
  localparam int CFG_W   = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CPU_CAPACITY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEMORY_CAPACITY = 1'd1;

  typedef struct packed {
    logic               cmd;
    logic [CPU_W-1:0]   cpu_demand;
    logic [MEM_W-1:0]   memory_demand;
    logic [INDEX_W-1:0] guest_index;
  } req_t;

  typedef struct packed {
    logic               accepted;
    logic [INDEX_W-1:0] result_index;
  } rsp_t;

  // One table entry as stored in the entry RAM.
  typedef struct packed {
    logic             running;
    logic [CPU_W-1:0] cpus;
    logic [MEM_W-1:0] memory;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* hw/rtl/vm_resource_admission.sv */
// Channel | Handshake           | Payload          | Direction
// req     | req_valid/req_stall | vra_pkg::req_t   | in
// rsp     | rsp_valid/rsp_stall | vra_pkg::rsp_t   | out
// cfg     | cfg_we              | cfg_index/data   | in
//
// One item per cycle while the response side does not stall. An accepted item sits
// in the request register while the entry RAM read completes; its result is then
// loaded into the response register once that register is free to take it.
// Reset clears capacities, the entry count and the running totals; the entry
// table itself is not cleared, since only entries below the count are read.
// A stalled response holds the request register; req_stall rises only then.
module vm_resource_admission #(
  parameter int MAX_GUESTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  vra_pkg::req_t                     req_item,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output vra_pkg::rsp_t                     rsp_item,
  input  logic                              cfg_we,
  input  logic [vra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vra_pkg::CFG_W-1:0]         cfg_data
);

  localparam int AW = (MAX_GUESTS > 1) ? $clog2(MAX_GUESTS) : 1;
  localparam int CW = $clog2(MAX_GUESTS + 1);
  localparam int CPU_W = vra_pkg::CPU_W;
  localparam int MEM_W = vra_pkg::MEM_W;

  // request stage
  logic          s1_valid;
  vra_pkg::req_t s1_item;
  logic          s1_adv;
  logic          req_acc;

  // state
  logic [CW-1:0]    entry_count;
  logic [CPU_W-1:0] cpus_in_use;
  logic [MEM_W-1:0] memory_in_use;
  logic [CPU_W-1:0] cpu_cap;
  logic [MEM_W-1:0] mem_cap;

  // bypass of a write that lands in the same edge as the read
  logic            fwd_hit;
  vra_pkg::entry_t fwd_data;

  // RAM
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  vra_pkg::entry_t               wr_data;
  logic [vra_pkg::ENTRY_W-1:0]   ram_rdata;
  vra_pkg::entry_t               ent;

  // decision
  logic          is_create;
  logic          create_ok;
  logic          idx_valid;
  logic          start_ok;
  logic [CPU_W:0] cpu_sum;
  logic [MEM_W:0] mem_sum;
  vra_pkg::rsp_t rsp_next;

  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_adv;
  assign req_acc   = req_valid && !req_stall;

  assign ent = fwd_hit ? fwd_data : vra_pkg::entry_t'(ram_rdata);

  always_comb begin
    is_create = (s1_item.cmd == vra_pkg::CMD_CREATE);
    create_ok = (entry_count < CW'(MAX_GUESTS)) && (s1_item.cpu_demand != '0)
                && (s1_item.memory_demand != '0);
    idx_valid = (9'(s1_item.guest_index) < 9'(entry_count));
    cpu_sum   = {1'b0, cpus_in_use} + {1'b0, ent.cpus};
    mem_sum   = {1'b0, memory_in_use} + {1'b0, ent.memory};
    start_ok  = idx_valid && !ent.running && (cpu_sum <= {1'b0, cpu_cap})
                && (mem_sum <= {1'b0, mem_cap});

    wr_en   = s1_adv && (is_create ? create_ok : start_ok);
    wr_addr = is_create ? entry_count[AW-1:0] : s1_item.guest_index[AW-1:0];
    if (is_create) begin
      wr_data.running = 1'b0;
      wr_data.cpus    = s1_item.cpu_demand;
      wr_data.memory  = s1_item.memory_demand;
    end else begin
      wr_data.running = 1'b1;
      wr_data.cpus    = ent.cpus;
      wr_data.memory  = ent.memory;
    end

    if (is_create) begin
      rsp_next.accepted     = create_ok;
      rsp_next.result_index = create_ok ? 8'(entry_count) : '0;
    end else begin
      rsp_next.accepted     = start_ok;
      rsp_next.result_index = s1_item.guest_index;
    end
  end

  vra_ram #(
    .WIDTH (vra_pkg::ENTRY_W),
    .DEPTH (MAX_GUESTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (req_acc),
    .raddr (req_item.guest_index[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      rsp_valid     <= 1'b0;
      entry_count   <= '0;
      cpus_in_use   <= '0;
      memory_in_use <= '0;
      cpu_cap       <= '0;
      mem_cap       <= '0;
      fwd_hit       <= 1'b0;
    end else begin
      if (req_acc) begin
        s1_valid <= 1'b1;
        fwd_hit  <= wr_en && (wr_addr == req_item.guest_index[AW-1:0]);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (wr_en && is_create) begin
        entry_count <= entry_count + CW'(1);
      end
      if (wr_en && !is_create) begin
        cpus_in_use   <= cpu_sum[CPU_W-1:0];
        memory_in_use <= mem_sum[MEM_W-1:0];
      end

      if (cfg_we) begin
        case (cfg_index)
          vra_pkg::REG_CPU_CAPACITY:    cpu_cap <= cfg_data[CPU_W-1:0];
          vra_pkg::REG_MEMORY_CAPACITY: mem_cap <= cfg_data[MEM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_item  <= req_item;
      fwd_data <= wr_data;
    end
    if (s1_adv) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

/* hw/rtl/vra_ram.sv */
module vra_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/vra_checker.sv */
`include "assert_macros.svh"

module vra_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input vra_pkg::rsp_t rsp_item,
  input logic          cfg_we
);

  logic req_acc;

  assign req_acc = req_valid && !req_stall;

  // a held response keeps its valid
  `CHK_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid, "response dropped")

  // a held response keeps its payload
  `CHK_NEXT(a_rsp_stable, clk, rst, rsp_valid && rsp_stall, $stable(rsp_item), "response changed")

  // the request side only stalls behind a full, stalled response register
  `CHK_SAME(a_stall_cause, clk, rst, req_stall, rsp_valid && rsp_stall, "needless stall")

  // an accepted item is followed by a waiting response
  `CHK_SAME(a_rsp_follows, clk, rst, req_acc, ##2 rsp_valid, "no response after item")

  // configuration writes do not disturb a waiting response
  `CHK_NEXT(a_cfg_quiet, clk, rst, cfg_we && rsp_valid && rsp_stall, rsp_valid, "response lost")

endmodule

bind vm_resource_admission vra_checker u_vra_checker (.*);

/* dv/vra_admission_checker.sv */
module vra_admission_checker
  import vra_pkg::*;
#(
  parameter int GUEST_SLOTS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_stall,
  input  req_t                 req_item,
  input  logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rsp_t                 rsp_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   outstanding,
  output int                   mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CPU_W-1:0] cpu_capacity;
  logic [MEM_W-1:0] memory_capacity;
  logic [CPU_W-1:0] guest_cpus    [GUEST_SLOTS];
  logic [MEM_W-1:0] guest_memory  [GUEST_SLOTS];
  logic             guest_running [GUEST_SLOTS];
  logic [8:0]       guests_created;
  logic [12:0]      cpus_running;
  logic [20:0]      memory_running;

  rsp_t pending_verdicts[$];

  function automatic rsp_t admit_request(input req_t r);
    rsp_t        verdict;
    logic [13:0] cpu_sum;
    logic [21:0] memory_sum;
    verdict = '0;
    if (r.cmd == CMD_CREATE) begin
      if (guests_created < GUEST_SLOTS && r.cpu_demand != '0 && r.memory_demand != '0) begin
        guest_cpus[guests_created]    = r.cpu_demand;
        guest_memory[guests_created]  = r.memory_demand;
        guest_running[guests_created] = 1'b0;
        verdict.accepted     = 1'b1;
        verdict.result_index = guests_created[INDEX_W-1:0];
        guests_created       = guests_created + 9'd1;
      end
    end else begin
      verdict.result_index = r.guest_index;
      if (r.guest_index < guests_created && r.guest_index < GUEST_SLOTS) begin
        if (!guest_running[r.guest_index]) begin
          cpu_sum    = cpus_running + guest_cpus[r.guest_index];
          memory_sum = memory_running + guest_memory[r.guest_index];
          // equality with the capacity still admits
          if (cpu_sum <= cpu_capacity && memory_sum <= memory_capacity) begin
            guest_running[r.guest_index] = 1'b1;
            cpus_running     = cpu_sum[12:0];
            memory_running   = memory_sum[20:0];
            verdict.accepted = 1'b1;
          end
        end
      end
    end
    return verdict;
  endfunction

  always @(posedge clk) begin : track
    rsp_t want;
    if (rst) begin
      cpu_capacity    = '0;
      memory_capacity = '0;
      guests_created  = '0;
      cpus_running    = '0;
      memory_running  = '0;
      pending_verdicts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CPU_CAPACITY:    cpu_capacity    = cfg_data[CPU_W-1:0];
          REG_MEMORY_CAPACITY: memory_capacity = cfg_data[MEM_W-1:0];
          default: ;
        endcase
      end
      // retire before predicting: a result never belongs to this edge's item
      if (rsp_valid && !rsp_stall) begin
        if (pending_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("%t: result with nothing expected: accepted=%0d index=%0d",
                     $realtime, rsp_item.accepted, rsp_item.result_index);
          mismatches = mismatches + 1;
        end else begin
          want = pending_verdicts.pop_front();
          if (rsp_item.accepted !== want.accepted ||
              rsp_item.result_index !== want.result_index) begin
            if (mismatches < 10)
              $display("%t: result mismatch: expected accepted=%0d index=%0d, got accepted=%0d index=%0d",
                       $realtime, want.accepted, want.result_index,
                       rsp_item.accepted, rsp_item.result_index);
            mismatches = mismatches + 1;
          end
        end
      end
      if (req_valid && !req_stall)
        pending_verdicts.push_back(admit_request(req_item));
    end
    outstanding = pending_verdicts.size();
  end

endmodule

/* dv/vm_resource_admission_tb.sv */
module vm_resource_admission_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vra_pkg::*;

  localparam int GUEST_SLOTS    = 16;
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int QUIET_LIMIT    = 2000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  req_t                 req_item  = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  rsp_t                 rsp_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int outstanding;
  int mismatches;
  int quiet_cycles = 0;
  int stall_left   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vm_resource_admission #(.MAX_GUESTS(GUEST_SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vra_admission_checker #(.GUEST_SLOTS(GUEST_SLOTS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req_item    (req_item),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp_item    (rsp_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // Receiver stalls: short runs mostly, now and then long stalls or long free stretches.
  always @(posedge clk) begin
    int unsigned pick;
    if (rst) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        rsp_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 12);
      end else if (pick < 88) begin
        rsp_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else if (pick < 96) begin
        rsp_stall  <= 1'b0;
        stall_left <= $urandom_range(30, 80);
      end else begin
        rsp_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic req_t make_req(input logic cmd, input logic [CPU_W-1:0] cpus,
                                    input logic [MEM_W-1:0] memory,
                                    input logic [INDEX_W-1:0] index);
    req_t r;
    r.cmd           = cmd;
    r.cpu_demand    = cpus;
    r.memory_demand = memory;
    r.guest_index   = index;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    r.cpu_demand    = CPU_W'($urandom);
    r.memory_demand = MEM_W'($urandom);
    r.guest_index   = INDEX_W'($urandom);
    pick  = $urandom_range(0, 99);
    r.cmd = (pick < 20) ? CMD_CREATE : CMD_START;
    if (pick < 4)
      r.cpu_demand = '0;
    else if (pick < 8)
      r.memory_demand = '0;
    // aim most starts at the table, just past its end included
    if (r.cmd == CMD_START && $urandom_range(0, 4) != 0)
      r.guest_index = INDEX_W'($urandom_range(0, GUEST_SLOTS + 1));
    return r;
  endfunction

  // Starts and ends in a rising-edge step.
  task automatic send_item(input req_t item, input bit no_gaps);
    int unsigned gap;
    logic        stalled;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do begin
      @(negedge clk);
      stalled = req_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_capacity(input logic [CPU_W-1:0] cpus, input logic [MEM_W-1:0] memory);
    // upper data bits are junk for the cpu register
    write_reg(REG_CPU_CAPACITY, {(CFG_W - CPU_W)'($urandom), cpus});
    write_reg(REG_MEMORY_CAPACITY, memory);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    bit burst;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    write_capacity('0, '0);
    @(posedge clk);
    send_item(make_req(CMD_CREATE, '0, 20'd5, 8'hff), 0);
    send_item(make_req(CMD_CREATE, 12'd9, '0, 8'h00), 0);
    send_item(make_req(CMD_CREATE, '1, '1, 8'haa), 0);
    send_item(make_req(CMD_CREATE, 12'd7, 20'd300, 8'h55), 0);
    send_item(make_req(CMD_START, '0, '0, 8'd0), 0);
    send_item(make_req(CMD_START, '1, '1, 8'd2), 0);
    send_item(make_req(CMD_START, '1, '1, 8'hff), 0);
    drain();

    // exactly enough for guest 1
    write_capacity(12'd7, 20'd300);
    send_item(make_req(CMD_START, '0, '0, 8'd1), 0);
    send_item(make_req(CMD_START, '0, '0, 8'd1), 0);
    send_item(make_req(CMD_START, '0, '0, 8'd0), 0);
    drain();

    write_capacity('1, '1);
    send_item(make_req(CMD_START, '0, '0, 8'd0), 1);
    drain();

    // lower below what is already running, then fill the table
    write_capacity(12'd3, 20'd100);
    for (int i = 2; i < GUEST_SLOTS; i++)
      send_item(make_req(CMD_CREATE, CPU_W'($urandom_range(1, 400)),
                         MEM_W'($urandom_range(1, 90000)), INDEX_W'($urandom)), 0);
    send_item(make_req(CMD_CREATE, 12'd1, 20'd1, 8'd0), 0);
    send_item(make_req(CMD_START, '0, '0, 8'd2), 0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 4))
        0:       write_capacity('0, '0);
        1:       write_capacity('1, '1);
        2:       write_capacity(CPU_W'($urandom), MEM_W'($urandom));
        3:       write_capacity(CPU_W'($urandom_range(0, 1500)),
                                MEM_W'($urandom_range(0, 400000)));
        default: write_capacity('1, MEM_W'($urandom));
      endcase
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_item(random_request(), burst);
      drain();
    end

    repeat (5) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
